[rtl/core/vxf_pkg.sv]
// Shared types and constants for the 4x4 vertex transform engine.
// Used by vxf_cell, vxf_out and vertex_transform_4x4; depends on nothing.
package vxf_pkg;

    // Geometry and arithmetic widths.
    localparam int N_DIM  = 4;
    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + 2;

    // Item kind carried in the input tuser.
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_XFORM = 1'b1
    } op_t;

    // One item as it travels down the chain of cells. Each cell consumes
    // vec[0] and column zero, then shifts the vector down and decrements
    // the column of the element index for its neighbor.
    typedef struct packed {
        op_t                                  op;
        logic [3:0]                           elem_index;
        logic [DATA_W-1:0]                    elem_value;
        logic [N_DIM-1:0][DATA_W-1:0]         vec;
        logic [N_DIM-1:0][SUM_W-1:0]          sum;
    } vxf_item_t;

endpackage

[rtl/core/vertex_transform_4x4.sv]
// Top level of the 4x4 vertex transform engine: a chain of four column
// cells followed by the saturating output stage. Depends on vxf_pkg,
// vxf_cell and vxf_out.
//
// The block accepts one transaction per clock cycle unless the chain is
// stalled, both element writes and vector transforms, and returns one
// result transaction per transform. The transform enters the first cell's
// multiply register at the edge that accepts it. Each of the four column
// cells then holds it in its multiply register and then in its accumulate
// register, and the output register presents it. Each cell holds one matrix
// column, which reset clears to zero. An element write travels down the
// chain like a transform and updates its column as it passes that cell, so
// every transform sees exactly the writes accepted before it. Every stage
// has its own valid bit, so bubbles close up and the chain keeps taking
// input while a result waits at the output, until all stages are full.
module vertex_transform_4x4 #(
    parameter int FRAC_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // Fields from bit 0: elem_index[3:0], elem_value[35:4], vec_x[67:36],
    // vec_y[99:68], vec_z[131:100], vec_w[163:132], zero fill.
    input  logic [167:0]  s_tdata,
    // Fields from bit 0: op.
    input  logic [0:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // Fields from bit 0: out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96].
    output logic [127:0]  m_tdata,
    // Fields from bit 0: saturated.
    output logic [0:0]    m_tuser
);

    logic [vxf_pkg::N_DIM:0]  chain_valid;
    logic [vxf_pkg::N_DIM:0]  chain_ready;
    vxf_pkg::vxf_item_t       chain_item [vxf_pkg::N_DIM+1];

    // Unpack the input transaction; partial sums start at zero.
    always_comb begin
        chain_item[0].op         = vxf_pkg::op_t'(s_tuser[0]);
        chain_item[0].elem_index = s_tdata[3:0];
        chain_item[0].elem_value = s_tdata[35:4];
        chain_item[0].vec[0]     = s_tdata[67:36];
        chain_item[0].vec[1]     = s_tdata[99:68];
        chain_item[0].vec[2]     = s_tdata[131:100];
        chain_item[0].vec[3]     = s_tdata[163:132];
        chain_item[0].sum        = '0;
    end

    assign chain_valid[0] = s_tvalid;
    assign s_tready       = chain_ready[0];

    // Chain of column cells.
    for (genvar c = 0; c < vxf_pkg::N_DIM; c++) begin : g_cell
        vxf_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[c]),
            .in_ready  (chain_ready[c]),
            .in_item   (chain_item[c]),
            .out_valid (chain_valid[c+1]),
            .out_ready (chain_ready[c+1]),
            .out_item  (chain_item[c+1])
        );
    end

    // Scaling, saturation and the result register.
    vxf_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (chain_valid[vxf_pkg::N_DIM]),
        .in_ready (chain_ready[vxf_pkg::N_DIM]),
        .in_item  (chain_item[vxf_pkg::N_DIM]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/core/vxf_cell.sv]
// One cell of the transform chain: holds one matrix column, multiplies it
// by one vector component and adds into the four partial sums.
// Depends on vxf_pkg.
module vxf_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  vxf_pkg::vxf_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output vxf_pkg::vxf_item_t  out_item
);

    // Column held by this cell, one element per row.
    logic signed [vxf_pkg::DATA_W-1:0] col_reg [vxf_pkg::N_DIM];

    // Multiply stage and accumulate stage.
    logic                               v1_reg, v1_next;
    logic                               v2_reg, v2_next;
    vxf_pkg::vxf_item_t                 s1_reg;
    vxf_pkg::vxf_item_t                 s2_reg, s2_next;
    logic signed [vxf_pkg::PROD_W-1:0]  prod_reg [vxf_pkg::N_DIM];
    logic                               ld1, ld2;
    logic                               wr_here;

    // Handshake between the two stages.
    assign ld2      = v1_reg && (!v2_reg || out_ready);
    assign in_ready = !v1_reg || ld2;
    assign ld1      = in_valid && in_ready;
    assign wr_here  = (in_item.op == vxf_pkg::OP_WRITE) && (in_item.elem_index[3:2] == 2'd0);

    always_comb begin
        v1_next = v1_reg;
        if (ld1) begin
            v1_next = 1'b1;
        end else if (ld2) begin
            v1_next = 1'b0;
        end
        v2_next = v2_reg;
        if (ld2) begin
            v2_next = 1'b1;
        end else if (out_ready) begin
            v2_next = 1'b0;
        end
    end

    // Accumulate, shift the vector down and step the element column.
    always_comb begin
        s2_next = s1_reg;
        s2_next.elem_index = {s1_reg.elem_index[3:2] - 2'd1, s1_reg.elem_index[1:0]};
        for (int c = 0; c < vxf_pkg::N_DIM - 1; c++) begin
            s2_next.vec[c] = s1_reg.vec[c+1];
        end
        s2_next.vec[vxf_pkg::N_DIM-1] = '0;
        for (int r = 0; r < vxf_pkg::N_DIM; r++) begin
            s2_next.sum[r] = s1_reg.sum[r]
                           + {{(vxf_pkg::SUM_W - vxf_pkg::PROD_W){prod_reg[r][vxf_pkg::PROD_W-1]}},
                              prod_reg[r]};
        end
    end

    // Control state and the matrix column.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int r = 0; r < vxf_pkg::N_DIM; r++) begin
                col_reg[r] <= '0;
            end
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            if (ld1 && wr_here) begin
                col_reg[in_item.elem_index[1:0]] <= in_item.elem_value;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (ld1) begin
            s1_reg <= in_item;
            for (int r = 0; r < vxf_pkg::N_DIM; r++) begin
                prod_reg[r] <= col_reg[r] * $signed(in_item.vec[0]);
            end
        end
        if (ld2) begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = s2_reg;

endmodule

[rtl/core/vxf_out.sv]
// Output stage: scales the sums down by the fraction bits, saturates to
// 32 bits and holds the result transaction. Write items are dropped here.
// Depends on vxf_pkg.
module vxf_out #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  vxf_pkg::vxf_item_t  in_item,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [127:0]        m_tdata,
    output logic [0:0]          m_tuser
);

    logic                                             oval_reg, oval_next;
    logic [vxf_pkg::N_DIM-1:0][vxf_pkg::DATA_W-1:0]  res_reg, res_next;
    logic                                             sat_reg, sat_next;
    logic                                             slot_free;
    logic                                             is_xform;
    logic                                             ld;
    logic signed [vxf_pkg::SUM_W-1:0]                 shifted;

    assign slot_free = !oval_reg || m_tready;
    assign is_xform  = (in_item.op == vxf_pkg::OP_XFORM);
    assign in_ready  = !is_xform || slot_free;
    assign ld        = in_valid && is_xform && slot_free;

    // Floor shift and clip of each component.
    always_comb begin
        res_next = '0;
        sat_next = 1'b0;
        shifted  = '0;
        for (int r = 0; r < vxf_pkg::N_DIM; r++) begin
            shifted = $signed(in_item.sum[r]) >>> FRAC_BITS;
            if (shifted[vxf_pkg::SUM_W-1:vxf_pkg::DATA_W-1] == '0 ||
                shifted[vxf_pkg::SUM_W-1:vxf_pkg::DATA_W-1] == '1) begin
                res_next[r] = shifted[vxf_pkg::DATA_W-1:0];
            end else begin
                sat_next = 1'b1;
                res_next[r] = shifted[vxf_pkg::SUM_W-1]
                            ? {1'b1, {(vxf_pkg::DATA_W-1){1'b0}}}
                            : {1'b0, {(vxf_pkg::DATA_W-1){1'b1}}};
            end
        end
    end

    always_comb begin
        oval_next = oval_reg;
        if (ld) begin
            oval_next = 1'b1;
        end else if (m_tready) begin
            oval_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oval_reg <= 1'b0;
        end else begin
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign m_tvalid = oval_reg;
    assign m_tdata  = res_reg;
    assign m_tuser  = sat_reg;

endmodule

[dv/tb.sv]
// Self-checking testbench for the 4x4 vertex transform engine (vertex_transform_4x4).
// Depends on vxf_pkg for the item kind and on the RTL of the engine; it reads no file
// and computes every expected transform with its own Q16.16 matrix model.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS     = 16;
    localparam int PIPE_LATENCY  = 9;
    localparam int RANDOM_ITEMS  = 750;
    localparam int CYCLE_LIMIT   = 200000;
    localparam logic signed [65:0] Q_MAX = 66'sh0_7FFF_FFFF;
    localparam logic signed [65:0] Q_MIN = -66'sh0_8000_0000;

    // One transformed vertex: components x, y, z, w from index 0 up.
    typedef struct packed {
        logic [3:0][31:0] comp;
        logic             sat;
    } xform_result_t;

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [167:0]  s_tdata;
    logic [0:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [127:0]  m_tdata;
    logic [0:0]    m_tuser;

    // Matrix as the engine should hold it, column-major, index column*4 + row.
    logic signed [31:0] matrix_elems [16];
    xform_result_t      expected_xforms [$];
    int                 error_count = 0;
    int                 items_sent  = 0;
    int                 cycle_count = 0;
    bit                 no_idle     = 1'b0;

    vertex_transform_4x4 #(
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit, so a hung handshake still ends the simulation.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run limit reached with %0d transforms outstanding",
                     $realtime, expected_xforms.size());
            $display("vertex_transform_4x4: mismatch");
            $finish;
        end
    end

    // Result side backpressure: about 30 percent stall, none during the quiet stretch.
    always @(negedge aclk) begin
        m_tready = no_idle || ($urandom_range(99) >= 30);
    end

    // Exact Q16.16 transform: full-width sums, floor shift, then clip to 32 bits.
    function automatic xform_result_t predict_transform(input logic [3:0][31:0] vec);
        xform_result_t      res;
        logic signed [65:0] acc;
        logic signed [65:0] shifted;
        res.sat = 1'b0;
        for (int r = 0; r < 4; r++) begin
            acc = '0;
            for (int c = 0; c < 4; c++) begin
                acc = acc + (matrix_elems[c * 4 + r] * $signed(vec[c]));
            end
            shifted = acc >>> FRAC_BITS;
            if (shifted > Q_MAX) begin
                shifted = Q_MAX;
                res.sat = 1'b1;
            end else if (shifted < Q_MIN) begin
                shifted = Q_MIN;
                res.sat = 1'b1;
            end
            res.comp[r] = shifted[31:0];
        end
        return res;
    endfunction

    // Mix of full-range values, corner values and small values that keep sums in range.
    function automatic logic [31:0] rand_q();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(9))
            0, 1: return v;
            2: begin
                case ($urandom_range(5))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    4: return 32'h0000_0001;
                    default: return 32'h0001_0000;
                endcase
            end
            default: return {{12{v[19]}}, v[19:0]};
        endcase
    endfunction

    function automatic logic [3:0][31:0] rand_vertex();
        logic [3:0][31:0] vec;
        for (int i = 0; i < 4; i++) begin
            vec[i] = rand_q();
        end
        return vec;
    endfunction

    // Present one item from a falling edge and hold it until the engine takes it.
    task automatic send_item(input vxf_pkg::op_t op, input logic [3:0] idx,
                             input logic [31:0] val, input logic [3:0][31:0] vec);
        if (!no_idle) begin
            while ($urandom_range(99) < 30) begin
                s_tvalid = 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {4'b0, vec[3], vec[2], vec[1], vec[0], val, idx};
        do @(posedge aclk); while (!s_tready);
        // The transaction is accepted at this edge.
        if (op == vxf_pkg::OP_WRITE) begin
            matrix_elems[idx] = val;
        end else begin
            expected_xforms.push_back(predict_transform(vec));
        end
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_transform(input logic [3:0][31:0] vec);
        send_item(vxf_pkg::OP_XFORM, 4'($urandom()), $urandom(), vec);
    endtask

    task automatic send_write(input logic [3:0] idx, input logic [31:0] val);
        send_item(vxf_pkg::OP_WRITE, idx, val, rand_vertex());
    endtask

    // Compare every result transaction with the oldest outstanding transform.
    always @(posedge aclk) begin
        xform_result_t exp_res;
        xform_result_t act_res;
        if (aresetn && m_tvalid && m_tready) begin
            act_res.comp = m_tdata;
            act_res.sat  = m_tuser[0];
            if (expected_xforms.size() == 0) begin
                $display("%0t: result with none outstanding, expected none, actual %h sat %b",
                         $realtime, act_res.comp, act_res.sat);
                error_count++;
            end else begin
                exp_res = expected_xforms.pop_front();
                for (int r = 0; r < 4; r++) begin
                    if (act_res.comp[r] !== exp_res.comp[r]) begin
                        $display("%0t: component %0d expected %h actual %h",
                                 $realtime, r, exp_res.comp[r], act_res.comp[r]);
                        error_count++;
                    end
                end
                if (act_res.sat !== exp_res.sat) begin
                    $display("%0t: saturated expected %b actual %b",
                             $realtime, exp_res.sat, act_res.sat);
                    error_count++;
                end
            end
        end
    end

    // A cleared matrix maps every vertex, extremes included, to zero.
    task automatic test_cleared_matrix();
        send_transform({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
        send_transform({32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000});
    endtask

    // Identity passes components through unchanged, with both sign extremes.
    task automatic test_identity();
        for (int i = 0; i < 16; i += 5) begin
            send_write(4'(i), 32'h0001_0000);
        end
        send_transform({32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF});
    endtask

    // Large elements push row sums past both ends of the 32-bit range.
    task automatic test_saturation();
        send_write(4'd0, 32'h7FFF_FFFF);
        send_write(4'd4, 32'h7FFF_FFFF);
        send_transform({32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_write(4'd0, 32'h8000_0000);
        send_transform({32'h0, 32'h0, 32'h0, 32'h8000_0000});
        send_transform({32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF});
    endtask

    // Tiny negative products must round toward minus infinity.
    task automatic test_rounding();
        send_write(4'd15, 32'h0000_0001);
        send_transform({32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0});
        send_transform({32'h0000_0001, 32'h0, 32'h0, 32'h0});
        send_item(vxf_pkg::OP_WRITE, 4'd15, 32'hFFFF_FFFF, {4{32'hFFFF_FFFF}});
        send_transform({32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0});
    endtask

    // Matrix reloads followed by vertex streams, with stray writes mid-stream.
    task automatic test_random_streams();
        int start;
        int n_writes;
        int n_verts;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            no_idle = (items_sent - start >= 300) && (items_sent - start < 450);
            n_writes = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 16;
            for (int i = 0; i < n_writes; i++) begin
                send_write((n_writes == 16) ? 4'(i) : 4'($urandom()), rand_q());
            end
            n_verts = $urandom_range(8, 40);
            for (int i = 0; i < n_verts; i++) begin
                if ($urandom_range(9) == 0) begin
                    send_write(4'($urandom()), rand_q());
                end else begin
                    send_transform(rand_vertex());
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        for (int i = 0; i < 16; i++) begin
            matrix_elems[i] = '0;
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_cleared_matrix();
        test_identity();
        test_saturation();
        test_rounding();
        test_random_streams();
        s_tvalid = 1'b0;

        // Drain the pipeline, then allow for any late stray result.
        while (expected_xforms.size() != 0) @(posedge aclk);
        repeat (2 * PIPE_LATENCY) @(posedge aclk);

        if (error_count == 0) begin
            $display("vertex_transform_4x4: match");
        end else begin
            $display("vertex_transform_4x4: mismatch");
        end
        $finish;
    end

endmodule
